FILE: src/cke_pkg.sv
package cke_pkg;

	localparam int KmerCodeW = 64;
	localparam int KmerLenW  = 6;

	typedef enum logic [1:0] {
		CFG_KMER_LENGTH   = 2'd0,
		CFG_STRANDED_MODE = 2'd1
	} cfg_index_t;

	typedef logic [1:0] base_t;

	typedef struct packed {
		logic [KmerCodeW-1:0] kmer_code;
		logic                 window_full;
		logic                 bad_char;
		logic                 took_reverse;
	} result_t;

	typedef struct packed {
		logic  is_base;
		base_t base;
	} base_dec_t;

	localparam logic [7:0] CharUpperA = 8'h41;
	localparam logic [7:0] CharUpperC = 8'h43;
	localparam logic [7:0] CharUpperG = 8'h47;
	localparam logic [7:0] CharUpperT = 8'h54;
	localparam logic [7:0] CharLowerA = 8'h61;
	localparam logic [7:0] CharLowerC = 8'h63;
	localparam logic [7:0] CharLowerG = 8'h67;
	localparam logic [7:0] CharLowerT = 8'h74;

	localparam base_t BaseA = 2'd0;
	localparam base_t BaseC = 2'd1;
	localparam base_t BaseG = 2'd2;
	localparam base_t BaseT = 2'd3;

	function automatic base_dec_t decode_base(input logic [7:0] ch);
		base_dec_t d;
		d.is_base = 1'b1;
		case (ch)
			CharUpperA, CharLowerA: d.base = BaseA;
			CharUpperC, CharLowerC: d.base = BaseC;
			CharUpperG, CharLowerG: d.base = BaseG;
			CharUpperT, CharLowerT: d.base = BaseT;
			default: begin
				d.is_base = 1'b0;
				d.base    = BaseA;
			end
		endcase
		return d;
	endfunction

endpackage

FILE: src/cke_kmer_calc.sv
module cke_kmer_calc
	import cke_pkg::*;
#(
	parameter int MAX_K = 32
) (
	input  logic [7:0]                        nuc_char,
	input  logic                              restart,
	input  logic [KmerLenW-1:0]               kmer_length,
	input  logic                              stranded_mode,
	input  logic [2*MAX_K-1:0]                fwd_cur,
	input  logic [2*MAX_K-1:0]                rev_cur,
	input  logic [$clog2(MAX_K+1)-1:0]        fill_cur,
	output logic [2*MAX_K-1:0]                fwd_next,
	output logic [2*MAX_K-1:0]                rev_next,
	output logic [$clog2(MAX_K+1)-1:0]        fill_next,
	output result_t                           result
);

	localparam int CodeW = 2 * MAX_K;
	localparam int FillW = $clog2(MAX_K + 1);
	localparam int ShW   = FillW + 1;
	localparam logic [ShW-1:0]   CodeWSh = ShW'(CodeW);
	localparam logic [FillW-1:0] MaxKF   = FillW'(MAX_K);

	base_dec_t            dec;
	logic [CodeW-1:0]     fwd_base;
	logic [CodeW-1:0]     rev_base;
	logic [FillW-1:0]     fill_base;
	logic [FillW-1:0]     k_eff;
	logic [ShW-1:0]       two_k;
	logic [CodeW-1:0]     mask;
	logic [CodeW-1:0]     fwd_k;
	logic [CodeW-1:0]     rc_k;
	logic                 full;
	logic                 use_rc;

	// Out-of-range lengths clamp to 1..MAX_K.
	always_comb begin
		if (kmer_length == '0) begin
			k_eff = FillW'(1);
		end else if ({1'b0, kmer_length} > (KmerLenW + 1)'(MAX_K)) begin
			k_eff = MaxKF;
		end else begin
			k_eff = FillW'(kmer_length);
		end
	end

	assign dec       = decode_base(nuc_char);
	assign fwd_base  = restart ? '0 : fwd_cur;
	assign rev_base  = restart ? '0 : rev_cur;
	assign fill_base = restart ? '0 : fill_cur;
	assign two_k     = {k_eff, 1'b0};

	always_comb begin
		if (dec.is_base) begin
			fwd_next  = (fwd_base << 2) | CodeW'(dec.base);
			rev_next  = (rev_base >> 2) | (CodeW'(~dec.base) << (CodeW - 2));
			fill_next = (fill_base < MaxKF) ? fill_base + FillW'(1) : fill_base;
		end else begin
			fwd_next  = '0;
			rev_next  = '0;
			fill_next = '0;
		end
	end

	assign mask   = ~({CodeW{1'b1}} << two_k);
	assign fwd_k  = fwd_next & mask;
	assign rc_k   = rev_next >> (CodeWSh - two_k);
	assign full   = dec.is_base && (fill_next >= k_eff);
	assign use_rc = full && !stranded_mode && (rc_k < fwd_k);

	always_comb begin
		result.window_full  = full;
		result.bad_char     = !dec.is_base;
		result.took_reverse = use_rc;
		if (!full) begin
			result.kmer_code = '0;
		end else if (use_rc) begin
			result.kmer_code = KmerCodeW'(rc_k);
		end else begin
			result.kmer_code = KmerCodeW'(fwd_k);
		end
	end

endmodule

FILE: src/canonical_kmer_stream_encoder.sv
// Canonical k-mer stream encoder.
// The item channel (item_valid, item_stall) carries one ASCII character per
// beat in nuc_char, with restart set on the first character of a sequence.
// The result channel (result_valid, result_stall) returns exactly one beat
// per item: the 2-bit packed k-mer in kmer_code, window_full, bad_char and
// took_reverse. In unstranded mode the smaller of the forward code and its
// reverse complement is reported.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes kmer_length at index 0 and stranded_mode at index 1. cfg_ready is
// always high; write only while no item is in flight.
// An accepted item sits in the input register, where the
// rolling window update, the reverse-complement alignment and the
// 2*MAX_K-bit compare run, and its result then moves into the output
// register, from which the result beat is offered.
// Throughput is one item per cycle as long as results are taken.
// When the receiver stalls, the result holds and the input register can
// still take one more item; item_stall rises only when both are occupied.
// Reset clears the window, the fill count, both pipeline valids and sets
// kmer_length to 31 and stranded_mode to 0.
module canonical_kmer_stream_encoder
	import cke_pkg::*;
#(
	parameter int MAX_K = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [7:0]            nuc_char,
	input  logic                  restart,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [KmerCodeW-1:0]  kmer_code,
	output logic                  window_full,
	output logic                  bad_char,
	output logic                  took_reverse,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [KmerLenW-1:0]   cfg_data
);

	localparam int CodeW = 2 * MAX_K;
	localparam int FillW = $clog2(MAX_K + 1);

	logic                 valid_s1;
	logic [7:0]           nuc_char_s1;
	logic                 restart_s1;
	logic                 result_valid_s2;
	result_t              result_s2;

	logic [CodeW-1:0]     fwd_q;
	logic [CodeW-1:0]     rev_q;
	logic [FillW-1:0]     fill_q;
	logic [KmerLenW-1:0]  kmer_length_q;
	logic                 stranded_q;

	logic [CodeW-1:0]     fwd_next;
	logic [CodeW-1:0]     rev_next;
	logic [FillW-1:0]     fill_next;
	result_t              result_next;
	logic                 advance_s1;
	logic                 cfg_write;

	assign advance_s1 = valid_s1 && !(result_valid_s2 && result_stall);
	assign item_stall = valid_s1 && !advance_s1;
	assign cfg_ready  = 1'b1;
	assign cfg_write  = cfg_valid && cfg_ready;

	cke_kmer_calc #(
		.MAX_K(MAX_K)
	) u_calc (
		.nuc_char      (nuc_char_s1),
		.restart       (restart_s1),
		.kmer_length   (kmer_length_q),
		.stranded_mode (stranded_q),
		.fwd_cur       (fwd_q),
		.rev_cur       (rev_q),
		.fill_cur      (fill_q),
		.fwd_next      (fwd_next),
		.rev_next      (rev_next),
		.fill_next     (fill_next),
		.result        (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KmerLenW'(31);
			stranded_q    <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_KMER_LENGTH:   kmer_length_q <= cfg_data;
				CFG_STRANDED_MODE: stranded_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			nuc_char_s1 <= nuc_char;
			restart_s1  <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			fill_q <= '0;
		end else if (advance_s1) begin
			fwd_q  <= fwd_next;
			rev_q  <= rev_next;
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_s2 <= result_next;
		end
	end

	assign result_valid = result_valid_s2;
	assign kmer_code    = result_s2.kmer_code;
	assign window_full  = result_s2.window_full;
	assign bad_char     = result_s2.bad_char;
	assign took_reverse = result_s2.took_reverse;

`ifndef SYNTHESIS
	a_bad_clears_window: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && result_next.bad_char |=> fill_q == '0 && fwd_q == '0 && rev_q == '0)
		else $error("window not cleared after a bad character");

	a_bad_result_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_char |-> !window_full && !took_reverse && kmer_code == '0)
		else $error("bad character beat carries a k-mer");

	a_reverse_only_unstranded: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && result_next.took_reverse |-> !stranded_q && result_next.window_full)
		else $error("reverse complement taken in stranded mode or before the window filled");

	a_stall_needs_full_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid_s2 && result_stall)
		else $error("input stalled with a free pipeline slot");
`endif

endmodule
